// File: src/ohlc_pkg.sv
// Package with the constants, codes and types of the OHLC bin aggregator.
package ohlc_pkg;

    localparam int NUM_BINS    = 1024;
    localparam int NUM_LINES   = 8;
    localparam int MAX_GROUPS  = 64;
    localparam int NUM_ENTRIES = NUM_BINS * NUM_LINES;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int LINE_AW     = $clog2(NUM_LINES);
    localparam int ENTRY_AW    = $clog2(NUM_ENTRIES);

    localparam int PRICE_W = 32;
    localparam int STAMP_W = 32;
    localparam int GSIZE_W = 11;
    localparam int GCNT_W  = 7;
    localparam int GOFFS_W = 12;
    localparam int GID_W   = 12;
    localparam int STAT_W  = 2;
    localparam int LINE_W  = 3;

    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 272;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BEFORE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BEYOND = 2'd2;

    typedef struct packed {
        logic                      valid;
        logic signed [PRICE_W-1:0] open;
        logic signed [PRICE_W-1:0] high;
        logic signed [PRICE_W-1:0] low;
        logic signed [PRICE_W-1:0] close;
        logic [STAMP_W-1:0]        first_stamp;
        logic [STAMP_W-1:0]        last_stamp;
    } entry_t;

    typedef enum logic [9:0] {
        ST_CLEAR   = 10'b0000000001,
        ST_IDLE    = 10'b0000000010,
        ST_DIV     = 10'b0000000100,
        ST_INS_CHK = 10'b0000001000,
        ST_INS_WR  = 10'b0000010000,
        ST_Q_SETUP = 10'b0000100000,
        ST_Q_GRP   = 10'b0001000000,
        ST_Q_RD    = 10'b0010000000,
        ST_Q_ACC   = 10'b0100000000,
        ST_EMIT    = 10'b1000000000
    } state_t;

endpackage

// File: src/ohlc_bin_aggregator_core.sv
// OHLC bin aggregator: inserts samples into a bin table and answers grouped queries.
//
// After reset the block clears the valid flags of its 8192-entry table, one entry per
// cycle, and accepts no item until the clear is done. For an insert, a shift-subtract
// divider computes the bin, then, unless the sample is rejected, the entry is read,
// merged and written back in the memory, and the result is presented. A query first
// uses the same divider to find the last group, then for each group starts it, reads
// its bins from the memory one by one, closes it and presents it; a group that starts
// below bin 0 is closed without reading any bin. Results are held until taken; the
// next item is accepted once the last result of this one is gone.
module ohlc_bin_aggregator_core
    import ohlc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,   // bin_width
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // line_id, stamp, price_open, price_high, price_low, price_close, group_size,
    // group_count, group_offset, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,       // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, group_id, group_empty, out_open, out_high, out_low, out_close,
    // range_min, range_max, data_min, data_max, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int POS_W = 26;
    localparam int K_W   = 14;
    localparam int GIDX_W = $clog2(MAX_GROUPS) + 1;

    entry_t mem [NUM_ENTRIES];
    entry_t rd_data_reg;
    logic                rd_en;
    logic [ENTRY_AW-1:0] rd_addr;
    logic                wr_en;
    logic [ENTRY_AW-1:0] wr_addr;
    entry_t              wr_data;

    state_t state_reg;
    logic [ENTRY_AW-1:0] clr_cnt_reg;
    logic [31:0] bin_width_reg;

    logic                      op_reg;
    logic [LINE_W-1:0]         line_reg;
    logic [STAMP_W-1:0]        stamp_reg;
    logic signed [PRICE_W-1:0] po_reg, ph_reg, pl_reg, pc_reg;
    logic [GSIZE_W-1:0]        gsize_reg;
    logic [GCNT_W-1:0]         count_reg;
    logic signed [GOFFS_W-1:0] offs_reg;

    logic                      started_reg;
    logic [STAMP_W-1:0]        start_reg;
    logic [BIN_W-1:0]          last_bin_reg;
    logic signed [PRICE_W-1:0] gmin_reg, gmax_reg;

    logic        neg_reg;
    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [4:0]  div_cnt_reg;
    logic [32:0] rem_shift;
    logic [BIN_W-1:0] bin_reg;

    logic signed [POS_W-1:0]   gstart_reg;
    logic [GID_W-1:0]          gid_reg;
    logic [GIDX_W-1:0]         gidx_reg;
    logic [GSIZE_W-1:0]        idx_reg;
    logic                      acc_empty_reg;
    logic signed [PRICE_W-1:0] acc_open_reg, acc_high_reg, acc_low_reg, acc_close_reg;
    logic                      have_range_reg;
    logic signed [PRICE_W-1:0] rmin_reg, rmax_reg;

    logic [STAT_W-1:0]         out_status_reg;
    logic [GID_W-1:0]          out_gid_reg;
    logic                      out_empty_reg;
    logic signed [PRICE_W-1:0] out_open_reg, out_high_reg, out_low_reg, out_close_reg;
    logic signed [PRICE_W-1:0] out_rmin_reg, out_rmax_reg;
    logic                      out_last_reg;

    // Input field views.
    logic [LINE_W-1:0]         in_line;
    logic [STAMP_W-1:0]        in_stamp;
    logic signed [PRICE_W-1:0] in_po, in_ph, in_pl, in_pc;
    logic [GSIZE_W-1:0]        in_gsize;
    logic [GCNT_W-1:0]         in_count;
    logic [GOFFS_W-1:0]        in_offs;

    assign in_line  = s_tdata[2:0];
    assign in_stamp = s_tdata[34:3];
    assign in_po    = s_tdata[66:35];
    assign in_ph    = s_tdata[98:67];
    assign in_pl    = s_tdata[130:99];
    assign in_pc    = s_tdata[162:131];
    assign in_gsize = s_tdata[173:163];
    assign in_count = s_tdata[180:174];
    assign in_offs  = s_tdata[192:181];

    logic              accept;
    logic [STAMP_W-1:0] start_eff;
    logic [32:0]       diff;
    logic [31:0]       diff_mag;
    logic [31:0]       width_eff;
    logic [GSIZE_W-1:0] gsize_eff;
    logic [GCNT_W-1:0] count_eff;

    assign accept    = s_tvalid && s_tready;
    assign start_eff = started_reg ? start_reg : in_stamp;
    assign diff      = {1'b0, in_stamp} - {1'b0, start_eff};
    assign diff_mag  = diff[32] ? 32'(-diff) : diff[31:0];
    assign width_eff = (bin_width_reg == '0) ? 32'd1 : bin_width_reg;
    assign gsize_eff = (in_gsize == '0) ? GSIZE_W'(1) : in_gsize;
    assign count_eff = (in_count > GCNT_W'(MAX_GROUPS)) ? GCNT_W'(MAX_GROUPS) : in_count;
    assign rem_shift = {rem_reg[31:0], quo_reg[31]};

    // Query setup arithmetic: first group index and its start bin.
    logic signed [K_W-1:0]   k_first;
    logic signed [POS_W-1:0] gstart_first;
    assign k_first = $signed({{(K_W-BIN_W){1'b0}}, quo_reg[BIN_W-1:0]})
                   + K_W'(offs_reg) - $signed({{(K_W-GCNT_W){1'b0}}, count_reg})
                   + K_W'(1);
    assign gstart_first = POS_W'(k_first) * $signed({{(POS_W-GSIZE_W){1'b0}}, gsize_reg});

    logic signed [POS_W-1:0] pos;
    logic                    grp_done;
    assign pos = gstart_reg + $signed({{(POS_W-GSIZE_W){1'b0}}, idx_reg});
    assign grp_done = ((state_reg == ST_Q_GRP) && gstart_reg[POS_W-1])
                   || ((state_reg == ST_Q_RD)
                       && ((idx_reg >= gsize_reg) || (pos >= POS_W'(NUM_BINS))));

    logic signed [PRICE_W-1:0] rmin_next, rmax_next;
    always_comb begin
        rmin_next = rmin_reg;
        rmax_next = rmax_reg;
        if (!acc_empty_reg) begin
            if (!have_range_reg) begin
                rmin_next = acc_low_reg;
                rmax_next = acc_high_reg;
            end else begin
                if (acc_low_reg < rmin_reg) rmin_next = acc_low_reg;
                if (acc_high_reg > rmax_reg) rmax_next = acc_high_reg;
            end
        end
    end

    // Merge of the stored entry with the current sample.
    entry_t merged;
    always_comb begin
        merged = rd_data_reg;
        if (!rd_data_reg.valid) begin
            merged.valid       = 1'b1;
            merged.open        = po_reg;
            merged.high        = ph_reg;
            merged.low         = pl_reg;
            merged.close       = pc_reg;
            merged.first_stamp = stamp_reg;
            merged.last_stamp  = stamp_reg;
        end else begin
            if (stamp_reg < rd_data_reg.first_stamp) begin
                merged.open        = po_reg;
                merged.first_stamp = stamp_reg;
            end
            if (stamp_reg > rd_data_reg.last_stamp) begin
                merged.close      = pc_reg;
                merged.last_stamp = stamp_reg;
            end
            if (ph_reg > rd_data_reg.high) merged.high = ph_reg;
            if (pl_reg < rd_data_reg.low) merged.low = pl_reg;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {bin_reg, line_reg[LINE_AW-1:0]};
        wr_en   = 1'b0;
        wr_addr = {bin_reg, line_reg[LINE_AW-1:0]};
        wr_data = merged;
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            ST_INS_CHK: begin
                rd_en   = 1'b1;
                rd_addr = {quo_reg[BIN_W-1:0], line_reg[LINE_AW-1:0]};
            end
            ST_INS_WR: begin
                wr_en = 1'b1;
            end
            ST_Q_RD: begin
                rd_en   = !grp_done;
                rd_addr = {pos[BIN_W-1:0], line_reg[LINE_AW-1:0]};
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, gmax_reg, gmin_reg, out_rmax_reg, out_rmin_reg,
                       out_close_reg, out_low_reg, out_high_reg, out_open_reg,
                       out_empty_reg, out_gid_reg, out_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            bin_width_reg <= 32'd1;
            started_reg   <= 1'b0;
            start_reg     <= '0;
            last_bin_reg  <= '0;
            gmin_reg      <= '0;
            gmax_reg      <= '0;
        end else begin
            if (cfg_wr_en) bin_width_reg <= cfg_wr_data;
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ENTRY_AW'(NUM_ENTRIES - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg      <= s_tuser[0];
                        line_reg    <= in_line;
                        stamp_reg   <= in_stamp;
                        po_reg      <= in_po;
                        ph_reg      <= in_ph;
                        pl_reg      <= in_pl;
                        pc_reg      <= in_pc;
                        gsize_reg   <= gsize_eff;
                        count_reg   <= count_eff;
                        offs_reg    <= in_offs;
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        if (s_tuser[0] == OP_INSERT) begin
                            if (!started_reg) begin
                                started_reg <= 1'b1;
                                start_reg   <= in_stamp;
                                gmin_reg    <= in_pl;
                                gmax_reg    <= in_ph;
                            end
                            neg_reg   <= diff[32];
                            quo_reg   <= diff_mag;
                            dvs_reg   <= width_eff;
                            state_reg <= ST_DIV;
                        end else if (in_count != '0) begin
                            neg_reg   <= 1'b0;
                            quo_reg   <= 32'(last_bin_reg);
                            dvs_reg   <= 32'(gsize_eff);
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (rem_shift >= {1'b0, dvs_reg}) begin
                        rem_reg <= rem_shift - {1'b0, dvs_reg};
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 5'd31) begin
                        state_reg <= (op_reg == OP_INSERT) ? ST_INS_CHK : ST_Q_SETUP;
                    end
                end
                ST_INS_CHK: begin
                    out_gid_reg   <= '0;
                    out_empty_reg <= 1'b0;
                    out_open_reg  <= '0;
                    out_high_reg  <= '0;
                    out_low_reg   <= '0;
                    out_close_reg <= '0;
                    out_rmin_reg  <= '0;
                    out_rmax_reg  <= '0;
                    out_last_reg  <= 1'b1;
                    bin_reg       <= quo_reg[BIN_W-1:0];
                    // A stamp less than one bin before the start still lands in bin 0.
                    if (neg_reg && (quo_reg != '0)) begin
                        out_status_reg <= STATUS_BEFORE;
                        state_reg      <= ST_EMIT;
                    end else if (quo_reg >= 32'(NUM_BINS)) begin
                        out_status_reg <= STATUS_BEYOND;
                        state_reg      <= ST_EMIT;
                    end else begin
                        out_status_reg <= STATUS_OK;
                        if (ph_reg > gmax_reg) gmax_reg <= ph_reg;
                        if (pl_reg < gmin_reg) gmin_reg <= pl_reg;
                        if (quo_reg[BIN_W-1:0] > last_bin_reg) begin
                            last_bin_reg <= quo_reg[BIN_W-1:0];
                        end
                        state_reg <= ST_INS_WR;
                    end
                end
                ST_INS_WR: begin
                    state_reg <= ST_EMIT;
                end
                ST_Q_SETUP: begin
                    gstart_reg     <= gstart_first;
                    gid_reg        <= k_first[GID_W-1:0];
                    gidx_reg       <= '0;
                    have_range_reg <= 1'b0;
                    rmin_reg       <= '0;
                    rmax_reg       <= '0;
                    idx_reg        <= '0;
                    acc_empty_reg  <= 1'b1;
                    acc_open_reg   <= '0;
                    acc_high_reg   <= '0;
                    acc_low_reg    <= '0;
                    acc_close_reg  <= '0;
                    state_reg      <= ST_Q_GRP;
                end
                ST_Q_GRP: begin
                    if (!grp_done) state_reg <= ST_Q_RD;
                end
                ST_Q_RD: begin
                    if (!grp_done) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_Q_ACC;
                    end
                end
                ST_Q_ACC: begin
                    if (rd_data_reg.valid) begin
                        acc_empty_reg <= 1'b0;
                        acc_close_reg <= rd_data_reg.close;
                        if (acc_empty_reg) begin
                            acc_open_reg <= rd_data_reg.open;
                            acc_high_reg <= rd_data_reg.high;
                            acc_low_reg  <= rd_data_reg.low;
                        end else begin
                            if (rd_data_reg.high > acc_high_reg) acc_high_reg <= rd_data_reg.high;
                            if (rd_data_reg.low < acc_low_reg) acc_low_reg <= rd_data_reg.low;
                        end
                    end
                    state_reg <= ST_Q_RD;
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (out_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            gidx_reg      <= gidx_reg + 1'b1;
                            gstart_reg    <= gstart_reg
                                           + $signed({{(POS_W-GSIZE_W){1'b0}}, gsize_reg});
                            gid_reg       <= gid_reg + 1'b1;
                            idx_reg       <= '0;
                            acc_empty_reg <= 1'b1;
                            acc_open_reg  <= '0;
                            acc_high_reg  <= '0;
                            acc_low_reg   <= '0;
                            acc_close_reg <= '0;
                            state_reg     <= ST_Q_GRP;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (grp_done) begin
                if (!acc_empty_reg) have_range_reg <= 1'b1;
                rmin_reg       <= rmin_next;
                rmax_reg       <= rmax_next;
                out_status_reg <= STATUS_OK;
                out_gid_reg    <= gid_reg;
                out_empty_reg  <= acc_empty_reg;
                out_open_reg   <= acc_open_reg;
                out_high_reg   <= acc_high_reg;
                out_low_reg    <= acc_low_reg;
                out_close_reg  <= acc_close_reg;
                out_rmin_reg   <= rmin_next;
                out_rmax_reg   <= rmax_next;
                out_last_reg   <= (gidx_reg == GIDX_W'(count_reg - 1'b1));
                state_reg      <= ST_EMIT;
            end
        end
    end

endmodule

// File: tb/tb_ohlc_bin_aggregator_core.sv
// Self-checking testbench for the OHLC bin aggregator: inserts, grouped queries, bin widths.
`timescale 1ns / 1ps

module tb_ohlc_bin_aggregator_core;
    import ohlc_pkg::*;

    localparam logic [31:0] BASE_STAMP = 32'h8000_0000;
    localparam int          SETTLE     = 200;

    typedef struct {
        logic        op;
        logic [2:0]  line;
        logic [31:0] stamp;
        logic [31:0] po, ph, pl, pc;
        logic [10:0] gsize;
        logic [6:0]  gcnt;
        logic [11:0] goffs;
    } sample_t;

    typedef struct {
        logic [1:0]  status;
        logic [11:0] gid;
        logic        empty;
        logic [31:0] o, h, l, c, rmin, rmax, dmin, dmax;
        logic        last;
    } bar_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [31:0]          cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    ohlc_bin_aggregator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Predictor state.
    logic [31:0] bin_width = 32'd1;
    bit          ent_valid [NUM_ENTRIES];
    int          ent_open  [NUM_ENTRIES];
    int          ent_high  [NUM_ENTRIES];
    int          ent_low   [NUM_ENTRIES];
    int          ent_close [NUM_ENTRIES];
    logic [31:0] ent_first [NUM_ENTRIES];
    logic [31:0] ent_last  [NUM_ENTRIES];
    bit          started = 0;
    logic [31:0] start_stamp = '0;
    int          last_bin = 0;
    int          data_lo = 0;
    int          data_hi = 0;

    sample_t pending_items[$];
    bar_t    expected_bars[$];
    int      mismatches = 0;
    int      accepted = 0;
    bit      rst_done = 0;
    bit      s_fire = 0;
    bit      m_fire = 0;
    bit      rx_hold = 0;

    function automatic void predict_insert(sample_t it);
        bar_t    r;
        longint  w, diff, bin;
        int      e, ph, pl;
        ph = it.ph;
        pl = it.pl;
        r = '{default: '0};
        if (!started) begin
            started = 1;
            start_stamp = it.stamp;
            data_lo = pl;
            data_hi = ph;
        end
        w = (bin_width == 0) ? 1 : longint'(bin_width);
        diff = longint'(it.stamp) - longint'(start_stamp);
        bin = diff / w;
        if (bin < 0) begin
            r.status = STATUS_BEFORE;
        end else if (bin >= NUM_BINS) begin
            r.status = STATUS_BEYOND;
        end else begin
            r.status = STATUS_OK;
            e = int'(bin) * NUM_LINES + it.line;
            if (ph > data_hi) data_hi = ph;
            if (pl < data_lo) data_lo = pl;
            if (int'(bin) > last_bin) last_bin = int'(bin);
            if (!ent_valid[e]) begin
                ent_valid[e] = 1;
                ent_open[e]  = it.po;
                ent_close[e] = it.pc;
                ent_high[e]  = ph;
                ent_low[e]   = pl;
                ent_first[e] = it.stamp;
                ent_last[e]  = it.stamp;
            end else begin
                if (it.stamp < ent_first[e]) begin
                    ent_open[e] = it.po;
                    ent_first[e] = it.stamp;
                end
                if (it.stamp > ent_last[e]) begin
                    ent_close[e] = it.pc;
                    ent_last[e] = it.stamp;
                end
                if (ph > ent_high[e]) ent_high[e] = ph;
                if (pl < ent_low[e]) ent_low[e] = pl;
            end
        end
        r.dmin = data_lo;
        r.dmax = data_hi;
        r.last = 1'b1;
        expected_bars.push_back(r);
    endfunction

    function automatic void predict_query(sample_t it);
        longint gs, cnt, offs, gstart, lastg, i;
        bit     have_range, empty;
        int     rmin, rmax, go, gh, gl, gc, e;
        bar_t   r;
        have_range = 0;
        rmin = 0;
        rmax = 0;
        gs = (it.gsize == 0) ? 1 : longint'(it.gsize);
        cnt = (it.gcnt > MAX_GROUPS) ? MAX_GROUPS : longint'(it.gcnt);
        offs = longint'($signed(it.goffs));
        lastg = last_bin - (last_bin % gs);
        gstart = lastg - cnt * gs + gs + offs * gs;
        for (longint g = 0; g < cnt; g++) begin
            empty = 1;
            go = 0; gh = 0; gl = 0; gc = 0;
            if (gstart >= 0) begin
                for (i = 0; i < gs && gstart + i < NUM_BINS; i++) begin
                    e = int'(gstart + i) * NUM_LINES + it.line;
                    if (!ent_valid[e]) continue;
                    if (empty) begin
                        empty = 0;
                        go = ent_open[e]; gh = ent_high[e];
                        gl = ent_low[e];  gc = ent_close[e];
                    end else begin
                        gc = ent_close[e];
                        if (ent_high[e] > gh) gh = ent_high[e];
                        if (ent_low[e] < gl) gl = ent_low[e];
                    end
                end
            end
            if (!empty) begin
                if (!have_range) begin
                    have_range = 1;
                    rmin = gl;
                    rmax = gh;
                end else begin
                    if (gh > rmax) rmax = gh;
                    if (gl < rmin) rmin = gl;
                end
            end
            r.status = STATUS_OK;
            r.gid = 12'(gstart / gs);
            r.empty = empty;
            r.o = go; r.h = gh; r.l = gl; r.c = gc;
            r.rmin = rmin; r.rmax = rmax;
            r.dmin = data_lo; r.dmax = data_hi;
            r.last = (g == cnt - 1);
            expected_bars.push_back(r);
            gstart += gs;
        end
    endfunction

    function automatic void check_field(string nm, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", nm, exp_v, act_v);
        end
    endfunction

    // Acceptance, prediction and result checking, all at the rising edge.
    always @(posedge aclk) begin
        bar_t    e;
        sample_t it;
        s_fire <= s_tvalid && s_tready;
        m_fire <= m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready) begin
            it.op    = s_tuser[0];
            it.line  = s_tdata[2:0];
            it.stamp = s_tdata[34:3];
            it.po    = s_tdata[66:35];
            it.ph    = s_tdata[98:67];
            it.pl    = s_tdata[130:99];
            it.pc    = s_tdata[162:131];
            it.gsize = s_tdata[173:163];
            it.gcnt  = s_tdata[180:174];
            it.goffs = s_tdata[192:181];
            accepted++;
            if (it.op == OP_INSERT) predict_insert(it);
            else predict_query(it);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", m_tdata);
            end else begin
                e = expected_bars.pop_front();
                check_field("status", e.status, m_tdata[1:0]);
                check_field("group_id", e.gid, m_tdata[13:2]);
                check_field("group_empty", e.empty, m_tdata[14]);
                check_field("out_open", e.o, m_tdata[46:15]);
                check_field("out_high", e.h, m_tdata[78:47]);
                check_field("out_low", e.l, m_tdata[110:79]);
                check_field("out_close", e.c, m_tdata[142:111]);
                check_field("range_min", e.rmin, m_tdata[174:143]);
                check_field("range_max", e.rmax, m_tdata[206:175]);
                check_field("data_min", e.dmin, m_tdata[238:207]);
                check_field("data_max", e.dmax, m_tdata[270:239]);
                check_field("last", e.last, m_tlast);
            end
        end
    end

    // Sender: one item per handshake, random gap before each, some stretches without gaps.
    int tx_gap = 0;
    bit tx_quiet = 0;
    always @(negedge aclk) begin
        sample_t it;
        if (rst_done && (!s_tvalid || s_fire)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                s_tdata <= {7'd0, it.goffs, it.gcnt, it.gsize, it.pc, it.pl, it.ph, it.po,
                            it.stamp, it.line};
                s_tuser <= it.op;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 14);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each result item, plus one long hold.
    int rx_gap = 0;
    bit rx_quiet = 0;
    always @(negedge aclk) begin
        if (m_fire) begin
            if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
            rx_gap = rx_quiet ? 0 : $urandom_range(0, 14);
        end
        if (rx_hold || rx_gap > 0) begin
            if (rx_gap > 0) rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Long receiver hold while the sender keeps offering items.
    initial begin
        wait (accepted >= 40);
        rx_hold = 1;
        repeat (600) @(posedge aclk);
        rx_hold = 0;
    end

    initial begin
        #40ms;
        $display("ohlc_bin_aggregator_core regression: fail");
        $finish;
    end

    function automatic sample_t mk_insert(logic [2:0] line, logic [31:0] stamp,
                                          logic [31:0] po, logic [31:0] ph,
                                          logic [31:0] pl, logic [31:0] pc);
        sample_t it;
        it = '{default: '0};
        it.op = OP_INSERT;
        it.line = line; it.stamp = stamp;
        it.po = po; it.ph = ph; it.pl = pl; it.pc = pc;
        it.gsize = 11'($urandom); it.gcnt = 7'($urandom); it.goffs = 12'($urandom);
        return it;
    endfunction

    function automatic sample_t mk_query(logic [2:0] line, logic [10:0] gsize,
                                         logic [6:0] gcnt, logic [11:0] goffs);
        sample_t it;
        it = '{default: '0};
        it.op = OP_QUERY;
        it.line = line; it.gsize = gsize; it.gcnt = gcnt; it.goffs = goffs;
        it.stamp = $urandom; it.po = $urandom; it.ph = $urandom;
        it.pl = $urandom; it.pc = $urandom;
        return it;
    endfunction

    // Mostly well-placed samples around a random mid price, some noise stamps and wild prices, and queries.
    function automatic sample_t rand_item(logic [31:0] w);
        logic [31:0] ww, stamp, mid, lo, hi;
        ww = (w == 0) ? 32'd1 : w;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
                0: return mk_query(3'($urandom), 11'($urandom_range(512, 2047)),
                                   7'($urandom_range(1, 3)), 12'($urandom_range(0, 2)));
                1: return mk_query(3'($urandom), 11'($urandom_range(0, 4)),
                                   7'($urandom_range(60, 127)), 12'($urandom));
                default: return mk_query(3'($urandom), 11'($urandom_range(0, 16)),
                                         7'($urandom_range(0, 8)),
                                         12'($signed($urandom_range(0, 5)) - 3));
            endcase
        end
        if ($urandom_range(0, 6) == 0) begin
            stamp = $urandom;
        end else begin
            stamp = BASE_STAMP + 32'($urandom_range(0, 1023)) * ww;
            stamp += (ww == 1) ? 32'd0 : 32'($urandom) % ww;
        end
        if ($urandom_range(0, 7) == 0) begin
            return mk_insert(3'($urandom), stamp, $urandom, $urandom, $urandom, $urandom);
        end
        mid = 32'($urandom_range(0, 4000)) << 8;
        lo = mid - 32'($urandom_range(0, 2000));
        hi = mid + 32'($urandom_range(0, 2000));
        return mk_insert(3'($urandom), stamp, mid + 32'($urandom_range(0, 100)), hi, lo,
                         mid - 32'($urandom_range(0, 100)));
    endfunction

    task automatic drain();
        do @(negedge aclk);
        while (pending_items.size() > 0 || s_tvalid || expected_bars.size() > 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_bin_width(logic [31:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        bin_width = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    logic [31:0] widths [5] = '{32'd16, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd1000};
    int          counts [5] = '{80, 60, 50, 50, 60};

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        // The table clears itself after reset; wait until the block is ready.
        do @(posedge aclk); while (!s_tready);
        for (int p = 0; p < 5; p++) begin
            write_bin_width(widths[p]);
            rst_done = 1;
            if (p == 0) begin
                pending_items.push_back(mk_insert(3'd0, BASE_STAMP, 32'h7FFF_FFFF,
                                                  32'h8000_0000, 32'h7FFF_FFFF,
                                                  32'h8000_0000));
                pending_items.push_back(mk_insert(3'd0, BASE_STAMP + 5, 32'd100, 32'd500,
                                                  32'hFFFF_0000, 32'd200));
                pending_items.push_back(mk_insert(3'd0, BASE_STAMP + 3, 32'd7, 32'd9, 32'd1,
                                                  32'd8));
                pending_items.push_back(mk_insert(3'd0, BASE_STAMP + 15, 32'd1, 32'd2, 32'd0,
                                                  32'd55));
                pending_items.push_back(mk_insert(3'd1, BASE_STAMP - 5, 32'd4, 32'd6, 32'd3,
                                                  32'd5));
                pending_items.push_back(mk_insert(3'd1, BASE_STAMP - 16, 32'd4, 32'd6, 32'd3,
                                                  32'd5));
                pending_items.push_back(mk_insert(3'd2, BASE_STAMP + 16 * 1024, 32'd4, 32'd6,
                                                  32'd3, 32'd5));
                pending_items.push_back(mk_insert(3'd7, BASE_STAMP + 16 * 1023,
                                                  32'h8000_0000, 32'h7FFF_FFFF,
                                                  32'h8000_0000, 32'h7FFF_FFFF));
                pending_items.push_back(mk_insert(3'd3, 32'd0, 32'd1, 32'd1, 32'd1, 32'd1));
                pending_items.push_back(mk_insert(3'd4, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1,
                                                  32'd1));
                pending_items.push_back(mk_insert(3'd7, BASE_STAMP + 16 * 40, 32'd10, 32'd30,
                                                  32'hFFFF_FFF0, 32'd20));
                pending_items.push_back(mk_query(3'd0, 11'd0, 7'd4, 12'd0));
                pending_items.push_back(mk_query(3'd0, 11'd1, 7'd0, 12'd0));
                pending_items.push_back(mk_query(3'd7, 11'd1, 7'd127, 12'd0));
                pending_items.push_back(mk_query(3'd7, 11'd16, 7'd64, 12'd0));
                pending_items.push_back(mk_query(3'd0, 11'd2047, 7'd2, 12'd0));
                pending_items.push_back(mk_query(3'd7, 11'd4, 7'd3, -12'sd1024));
                pending_items.push_back(mk_query(3'd0, 11'd1, 7'd3, 12'd1024));
                pending_items.push_back(mk_query(3'd0, 11'd1, 7'd2, 12'h800));
                pending_items.push_back(mk_query(3'd0, 11'd1, 7'd2, 12'h7FF));
                pending_items.push_back(mk_query(3'd5, 11'd8, 7'd5, 12'd0));
                pending_items.push_back(mk_query(3'd0, 11'd1024, 7'd1, 12'd0));
            end
            for (int k = 0; k < counts[p]; k++)
                pending_items.push_back(rand_item(widths[p]));
            // The sender pauses here until every outstanding result has come back.
            drain();
        end
        if (mismatches == 0) begin
            $display("ohlc_bin_aggregator_core regression: pass");
        end else begin
            $display("ohlc_bin_aggregator_core regression: fail");
        end
        $finish;
    end

endmodule
